FILE: design/pcd_pkg.sv
package pcd_pkg;

	// Chunk type words, first character in the top byte
	localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
	localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
	localparam logic [31:0] TYPE_PLTE = 32'h504C_5445;
	localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

	// Signature bytes skipped at the head of the file
	localparam int unsigned SIG_BYTES = 8;

	// Chunk class codes
	localparam logic [2:0] CLS_OTHER = 3'd0;
	localparam logic [2:0] CLS_IHDR  = 3'd1;
	localparam logic [2:0] CLS_IDAT  = 3'd2;
	localparam logic [2:0] CLS_PLTE  = 3'd3;
	localparam logic [2:0] CLS_IEND  = 3'd4;

	// One finished chunk with the header fields current at its end
	typedef struct packed {
		logic [2:0]  chunk_class;
		logic [31:0] chunk_type_code;
		logic [31:0] chunk_length;
		logic [31:0] stored_crc;
		logic [31:0] image_width;
		logic [31:0] image_height;
		logic [7:0]  depth_bits;
		logic [7:0]  colour_type;
		logic [7:0]  compression_kind;
		logic [7:0]  filter_kind;
		logic [7:0]  interlace_kind;
		logic [15:0] zlib_header;
	} chunk_info_t;

	function automatic logic [2:0] class_of(input logic [31:0] t);
		logic [2:0] c;
		c = CLS_OTHER;
		if (t == TYPE_IHDR) c = CLS_IHDR;
		else if (t == TYPE_IDAT) c = CLS_IDAT;
		else if (t == TYPE_PLTE) c = CLS_PLTE;
		else if (t == TYPE_IEND) c = CLS_IEND;
		return c;
	endfunction

endpackage

FILE: design/pcd_parser.sv
module pcd_parser
	import pcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  file_byte,
	output logic        emit_next,
	output chunk_info_t info
);

	typedef enum logic [2:0] {
		PH_SIG,
		PH_LEN,
		PH_TYPE,
		PH_DATA,
		PH_CRC,
		PH_DONE
	} phase_t;

	localparam int unsigned SIG_W = $clog2(SIG_BYTES);

	phase_t            phase_q;
	logic [SIG_W-1:0]  sig_cnt_q;
	logic [31:0]       cnt_q;
	logic [31:0]       len_q;
	logic [31:0]       type_q;
	logic [31:0]       crc_q;
	logic [31:0]       width_q;
	logic [31:0]       height_q;
	logic [7:0]        depth_q;
	logic [7:0]        colour_q;
	logic [7:0]        compress_q;
	logic [7:0]        filter_q;
	logic [7:0]        interlace_q;
	logic [15:0]       zlib_q;

	logic [31:0] cnt_inc;
	logic        low_off;

	assign cnt_inc = cnt_q + 32'd1;
	assign low_off = (cnt_q[31:4] == 28'd0);

	// The next transfer carries the last CRC byte of a chunk
	assign emit_next = (phase_q == PH_CRC) && (cnt_q == 32'd3);

	// Result as it stands once the last CRC byte arrives
	always_comb begin
		info.chunk_class      = class_of(type_q);
		info.chunk_type_code  = type_q;
		info.chunk_length     = len_q;
		info.stored_crc       = {crc_q[23:0], file_byte};
		info.image_width      = width_q;
		info.image_height     = height_q;
		info.depth_bits       = depth_q;
		info.colour_type      = colour_q;
		info.compression_kind = compress_q;
		info.filter_kind      = filter_q;
		info.interlace_kind   = interlace_q;
		info.zlib_header      = zlib_q;
	end

	// Advance the chunk walk one byte per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SIG;
			sig_cnt_q   <= '0;
			cnt_q       <= '0;
			len_q       <= '0;
			type_q      <= '0;
			crc_q       <= '0;
			width_q     <= '0;
			height_q    <= '0;
			depth_q     <= '0;
			colour_q    <= '0;
			compress_q  <= '0;
			filter_q    <= '0;
			interlace_q <= '0;
			zlib_q      <= '0;
		end else if (take) begin
			unique case (phase_q)
				PH_SIG: begin
					sig_cnt_q <= sig_cnt_q + 1'b1;
					if (sig_cnt_q == SIG_W'(SIG_BYTES - 1)) begin
						phase_q <= PH_LEN;
						cnt_q   <= '0;
					end
				end
				PH_LEN: begin
					len_q <= {len_q[23:0], file_byte};
					if (cnt_q == 32'd3) begin
						phase_q <= PH_TYPE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_inc;
					end
				end
				PH_TYPE: begin
					type_q <= {type_q[23:0], file_byte};
					if (cnt_q == 32'd3) begin
						phase_q <= (len_q == 32'd0) ? PH_CRC : PH_DATA;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_inc;
					end
				end
				PH_DATA: begin
					// Capture header bytes by offset within the chunk data
					if (type_q == TYPE_IHDR && low_off) begin
						case (cnt_q[3:0])
							4'd0:  width_q[31:24]  <= file_byte;
							4'd1:  width_q[23:16]  <= file_byte;
							4'd2:  width_q[15:8]   <= file_byte;
							4'd3:  width_q[7:0]    <= file_byte;
							4'd4:  height_q[31:24] <= file_byte;
							4'd5:  height_q[23:16] <= file_byte;
							4'd6:  height_q[15:8]  <= file_byte;
							4'd7:  height_q[7:0]   <= file_byte;
							4'd8:  depth_q         <= file_byte;
							4'd9:  colour_q        <= file_byte;
							4'd10: compress_q      <= file_byte;
							4'd11: filter_q        <= file_byte;
							4'd12: interlace_q     <= file_byte;
							default: ;
						endcase
					end else if (type_q == TYPE_IDAT) begin
						if (cnt_q == 32'd0) zlib_q[15:8] <= file_byte;
						else if (cnt_q == 32'd1) zlib_q[7:0] <= file_byte;
					end
					if (cnt_inc == len_q) begin
						phase_q <= PH_CRC;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_inc;
					end
				end
				PH_CRC: begin
					crc_q <= {crc_q[23:0], file_byte};
					if (cnt_q == 32'd3) begin
						cnt_q   <= '0;
						phase_q <= (type_q == TYPE_IEND) ? PH_DONE : PH_LEN;
					end else begin
						cnt_q <= cnt_inc;
					end
				end
				PH_DONE: ;
				default: phase_q <= PH_DONE;
			endcase
		end
	end

endmodule

FILE: design/png_chunk_deframer.sv
// Channel  | Direction | Handshake                | Payload
// file     | in        | file_valid / file_stall  | file_byte
// chunk    | out       | chunk_valid / chunk_stall| chunk_class .. zlib_header
//
// One byte is taken per cycle while file_stall is low; the result of a chunk
// shows on the cycle after its last CRC byte, out of a single output register.
// Reset clears the walk to the signature phase and all header fields to zero.
// file_stall rises only when the next byte would finish a chunk while the
// output register still holds a result that chunk_stall keeps back.
// After the IEND chunk every byte is taken and dropped.
module png_chunk_deframer
	import pcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        file_valid,
	output logic        file_stall,
	input  logic [7:0]  file_byte,
	output logic        chunk_valid,
	input  logic        chunk_stall,
	output logic [2:0]  chunk_class,
	output logic [31:0] chunk_type_code,
	output logic [31:0] chunk_length,
	output logic [31:0] stored_crc,
	output logic [31:0] image_width,
	output logic [31:0] image_height,
	output logic [7:0]  depth_bits,
	output logic [7:0]  colour_type,
	output logic [7:0]  compression_kind,
	output logic [7:0]  filter_kind,
	output logic [7:0]  interlace_kind,
	output logic [15:0] zlib_header
);

	logic        take;
	logic        emit_next;
	chunk_info_t info;
	chunk_info_t res_q;
	logic        res_valid_q;

	assign file_stall = res_valid_q && chunk_stall && emit_next;
	assign take       = file_valid && !file_stall;

	pcd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.file_byte (file_byte),
		.emit_next (emit_next),
		.info      (info)
	);

	// Hold the result until the chunk transfer completes; load a new one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && emit_next) begin
			res_valid_q <= 1'b1;
		end else if (!chunk_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit_next) begin
			res_q <= info;
		end
	end

	assign chunk_valid      = res_valid_q;
	assign chunk_class      = res_q.chunk_class;
	assign chunk_type_code  = res_q.chunk_type_code;
	assign chunk_length     = res_q.chunk_length;
	assign stored_crc       = res_q.stored_crc;
	assign image_width      = res_q.image_width;
	assign image_height     = res_q.image_height;
	assign depth_bits       = res_q.depth_bits;
	assign colour_type      = res_q.colour_type;
	assign compression_kind = res_q.compression_kind;
	assign filter_kind      = res_q.filter_kind;
	assign interlace_kind   = res_q.interlace_kind;
	assign zlib_header      = res_q.zlib_header;

endmodule

FILE: design/pcd_checker.sv
module pcd_checker
	import pcd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        chunk_valid,
	input logic        chunk_stall,
	input logic [2:0]  chunk_class,
	input logic [31:0] chunk_type_code,
	input logic [31:0] chunk_length
);

	// A stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_valid && chunk_stall |=> chunk_valid && $stable(chunk_type_code)
			&& $stable(chunk_length) && $stable(chunk_class))
		else $error("stalled chunk result changed");

	// Class code stays within the defined set
	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_valid |-> chunk_class <= CLS_IEND)
		else $error("chunk class out of range");

	// Class agrees with the raw type word for IHDR and IEND
	a_class_type: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_valid |-> ((chunk_class == CLS_IHDR) == (chunk_type_code == TYPE_IHDR))
			&& ((chunk_class == CLS_IEND) == (chunk_type_code == TYPE_IEND)))
		else $error("chunk class does not match type");

	// Nothing follows the end-of-stream chunk
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_valid && !chunk_stall && chunk_class == CLS_IEND |=> !chunk_valid)
		else $error("result after end of stream");

endmodule

bind png_chunk_deframer pcd_checker u_pcd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.chunk_valid     (chunk_valid),
	.chunk_stall     (chunk_stall),
	.chunk_class     (chunk_class),
	.chunk_type_code (chunk_type_code),
	.chunk_length    (chunk_length)
);

FILE: sim/png_chunk_deframer_tb.sv
module png_chunk_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pcd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned PHASE_BYTES = 130;
	localparam int unsigned TAIL_BYTES  = 40;
	localparam int unsigned DRAIN_WAIT  = 16;

	// Predicts the chunk records of one file and checks them in order
	class chunk_scoreboard;
		typedef enum logic [2:0] {
			WALK_SIG, WALK_LEN, WALK_TYPE, WALK_DATA, WALK_CRC, WALK_DONE
		} walk_t;

		walk_t       walk;
		int unsigned sig_seen;
		logic [31:0] count;
		logic [31:0] len_word;
		logic [31:0] type_word;
		logic [31:0] crc_word;
		chunk_info_t hdr;
		chunk_info_t expected_chunks[$];
		int unsigned mismatches;
		int unsigned chunks_checked;
		int unsigned per_class[5];

		function new();
			walk = WALK_SIG;
			sig_seen = 0;
			count = '0;
			len_word = '0;
			type_word = '0;
			crc_word = '0;
			hdr = '0;
			mismatches = 0;
			chunks_checked = 0;
			foreach (per_class[i]) per_class[i] = 0;
		endfunction

		function int unsigned pending();
			return expected_chunks.size();
		endfunction

		function logic [2:0] class_for(logic [31:0] t);
			case (t)
				TYPE_IHDR: return CLS_IHDR;
				TYPE_IDAT: return CLS_IDAT;
				TYPE_PLTE: return CLS_PLTE;
				TYPE_IEND: return CLS_IEND;
				default:   return CLS_OTHER;
			endcase
		endfunction

		// Latch header bytes at their offsets inside IHDR and IDAT data
		function void capture(logic [31:0] off, logic [7:0] b);
			if (type_word == TYPE_IHDR) begin
				if (off < 4)
					hdr.image_width[8 * (3 - off) +: 8] = b;
				else if (off < 8)
					hdr.image_height[8 * (7 - off) +: 8] = b;
				else if (off == 8)
					hdr.depth_bits = b;
				else if (off == 9)
					hdr.colour_type = b;
				else if (off == 10)
					hdr.compression_kind = b;
				else if (off == 11)
					hdr.filter_kind = b;
				else if (off == 12)
					hdr.interlace_kind = b;
			end else if (type_word == TYPE_IDAT) begin
				if (off == 0)
					hdr.zlib_header[15:8] = b;
				else if (off == 1)
					hdr.zlib_header[7:0] = b;
			end
		endfunction

		// Advance the chunk walk by one accepted file byte
		function void note_byte(logic [7:0] b);
			chunk_info_t rec;
			case (walk)
				WALK_SIG: begin
					sig_seen++;
					if (sig_seen >= SIG_BYTES) begin
						walk = WALK_LEN;
						count = '0;
					end
				end
				WALK_LEN: begin
					len_word = {len_word[23:0], b};
					count++;
					if (count == 4) begin
						walk = WALK_TYPE;
						count = '0;
					end
				end
				WALK_TYPE: begin
					type_word = {type_word[23:0], b};
					count++;
					if (count == 4) begin
						walk = (len_word == 0) ? WALK_CRC : WALK_DATA;
						count = '0;
					end
				end
				WALK_DATA: begin
					capture(count, b);
					count++;
					if (count == len_word) begin
						walk = WALK_CRC;
						count = '0;
					end
				end
				WALK_CRC: begin
					crc_word = {crc_word[23:0], b};
					count++;
					if (count == 4) begin
						count = '0;
						rec = hdr;
						rec.chunk_class = class_for(type_word);
						rec.chunk_type_code = type_word;
						rec.chunk_length = len_word;
						rec.stored_crc = crc_word;
						expected_chunks.push_back(rec);
						walk = (type_word == TYPE_IEND) ? WALK_DONE : WALK_LEN;
					end
				end
				default: ;
			endcase
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				mismatches++;
				$display("%0t: chunk %0d %s: expected %0h, got %0h",
					$time, chunks_checked, field, want, got);
			end
		endfunction

		// Check one transfer on the chunk channel against the oldest prediction
		function void check_chunk(chunk_info_t got);
			chunk_info_t want;
			if (expected_chunks.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected chunk, expected none, got type %0h length %0h",
					$time, got.chunk_type_code, got.chunk_length);
				return;
			end
			want = expected_chunks.pop_front();
			compare("chunk_class", want.chunk_class, got.chunk_class);
			compare("chunk_type_code", want.chunk_type_code, got.chunk_type_code);
			compare("chunk_length", want.chunk_length, got.chunk_length);
			compare("stored_crc", want.stored_crc, got.stored_crc);
			compare("image_width", want.image_width, got.image_width);
			compare("image_height", want.image_height, got.image_height);
			compare("depth_bits", want.depth_bits, got.depth_bits);
			compare("colour_type", want.colour_type, got.colour_type);
			compare("compression_kind", want.compression_kind, got.compression_kind);
			compare("filter_kind", want.filter_kind, got.filter_kind);
			compare("interlace_kind", want.interlace_kind, got.interlace_kind);
			compare("zlib_header", want.zlib_header, got.zlib_header);
			if (want.chunk_class <= CLS_IEND)
				per_class[want.chunk_class]++;
			chunks_checked++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        file_valid;
	logic        file_stall;
	logic [7:0]  file_byte;
	logic        chunk_valid;
	logic        chunk_stall;
	logic [2:0]  chunk_class;
	logic [31:0] chunk_type_code;
	logic [31:0] chunk_length;
	logic [31:0] stored_crc;
	logic [31:0] image_width;
	logic [31:0] image_height;
	logic [7:0]  depth_bits;
	logic [7:0]  colour_type;
	logic [7:0]  compression_kind;
	logic [7:0]  filter_kind;
	logic [7:0]  interlace_kind;
	logic [15:0] zlib_header;

	chunk_scoreboard sb = new();

	int unsigned cycles;
	int unsigned bytes_sent;
	int unsigned src_idle_pct;
	int unsigned dst_stall_pct;
	int unsigned holds_asked;
	int unsigned holds_served;
	int unsigned hold_left;

	png_chunk_deframer DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.file_valid       (file_valid),
		.file_stall       (file_stall),
		.file_byte        (file_byte),
		.chunk_valid      (chunk_valid),
		.chunk_stall      (chunk_stall),
		.chunk_class      (chunk_class),
		.chunk_type_code  (chunk_type_code),
		.chunk_length     (chunk_length),
		.stored_crc       (stored_crc),
		.image_width      (image_width),
		.image_height     (image_height),
		.depth_bits       (depth_bits),
		.colour_type      (colour_type),
		.compression_kind (compression_kind),
		.filter_kind      (filter_kind),
		.interlace_kind   (interlace_kind),
		.zlib_header      (zlib_header)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Count cycles for the run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("%0t: run limit reached with %0d chunks outstanding", $time, sb.pending());
		$display("end of test: mismatches");
		$finish;
	end

	// Receiver: long hold-off on request, random stall otherwise
	always @(posedge clk) begin
		if (holds_served != holds_asked) begin
			holds_served <= holds_asked;
			hold_left <= HOLD_CYCLES;
			chunk_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			chunk_stall <= 1'b1;
		end else begin
			chunk_stall <= ($urandom_range(0, 99) < dst_stall_pct);
		end
	end

	// Watch both channels; note input transfers before checking output ones
	always @(posedge clk) begin
		if (arst_n) begin
			if (file_valid && !file_stall)
				sb.note_byte(file_byte);
			if (chunk_valid && !chunk_stall)
				sb.check_chunk({chunk_class, chunk_type_code, chunk_length, stored_crc,
					image_width, image_height, depth_bits, colour_type,
					compression_kind, filter_kind, interlace_kind, zlib_header});
		end
	end

	// Offer one byte, idling at random first, and hold it until taken
	task automatic send_byte(input logic [7:0] b);
		while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			file_valid <= 1'b0;
			@(posedge clk);
		end
		file_valid <= 1'b1;
		file_byte <= b;
		@(posedge clk);
		while (file_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			send_byte(w[8 * i +: 8]);
	endtask

	// One chunk; fill below zero gives random data bytes
	task automatic send_chunk(input logic [31:0] typ, input logic [31:0] len,
			input logic [31:0] crc, input int fill);
		send_word(len);
		send_word(typ);
		for (longint unsigned k = 0; k < len; k++)
			send_byte(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
		send_word(crc);
	endtask

	// Mostly known types with random content, some near misses and noise types
	task automatic send_random_chunk();
		logic [31:0] typ;
		logic [31:0] len;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			typ = TYPE_IHDR;
		else if (pick < 50)
			typ = TYPE_IDAT;
		else if (pick < 60)
			typ = TYPE_PLTE;
		else if (pick < 75) begin
			case ($urandom_range(0, 2))
				0:       typ = TYPE_IHDR;
				1:       typ = TYPE_IDAT;
				default: typ = TYPE_PLTE;
			endcase
			typ ^= 32'h1 << $urandom_range(0, 31);
		end else
			typ = $urandom;
		if (typ == TYPE_IEND)
			typ ^= 32'h1;
		pick = $urandom_range(0, 99);
		if (typ == TYPE_IHDR && pick < 50)
			len = 13;
		else if (pick < 10)
			len = 0;
		else if (pick < 80)
			len = $urandom_range(1, 16);
		else if (pick < 96)
			len = $urandom_range(17, 64);
		else
			len = $urandom_range(65, 300);
		send_chunk(typ, len, $urandom, -1);
	endtask

	initial begin
		int unsigned phase_start;
		arst_n = 1'b0;
		file_valid = 1'b0;
		file_byte = '0;
		chunk_stall = 1'b0;
		cycles = 0;
		bytes_sent = 0;
		src_idle_pct = 0;
		dst_stall_pct = 0;
		holds_asked = 0;
		holds_served = 0;
		hold_left = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: signature, then header extremes and the odd chunk shapes
		send_word(32'h8950_4E47);
		send_word(32'h0D0A_1A0A);
		send_chunk(32'h7445_5874, 7, 32'h1234_5678, -1);
		send_chunk(TYPE_IHDR, 13, 32'hFFFF_FFFF, 255);
		send_chunk(TYPE_IDAT, 2, 32'hFFFF_FFFF, 255);
		send_chunk(TYPE_IHDR, 13, 32'h0000_0000, 0);
		send_chunk(TYPE_IDAT, 2, 32'h0000_0000, 0);
		send_chunk(TYPE_IHDR, 13, $urandom, -1);
		send_chunk(TYPE_IHDR, 5, $urandom, -1);
		send_chunk(TYPE_IHDR, 20, $urandom, -1);
		send_chunk(TYPE_IDAT, 1, $urandom, -1);
		send_chunk(TYPE_IDAT, 0, $urandom, -1);
		send_chunk(TYPE_IDAT, 37, $urandom, -1);
		send_chunk(TYPE_PLTE, 6, $urandom, -1);
		send_chunk(TYPE_PLTE, 0, $urandom, -1);
		send_chunk(TYPE_IHDR, 0, $urandom, -1);
		send_chunk(TYPE_IHDR ^ 32'h1, 13, $urandom, -1);
		send_chunk(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, -1);
		send_chunk(32'h0000_0000, 3, 32'h0000_0000, -1);
		send_chunk(32'h7A54_5874, 32'h0000_0105, $urandom, -1);

		// Random chunks under four idle mixes
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					src_idle_pct = 0;
					dst_stall_pct = 0;
					holds_asked++;
				end
				1: begin
					src_idle_pct = 63;
					dst_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					dst_stall_pct = 63;
					// pause the file until every chunk so far is out
					file_valid <= 1'b0;
					@(posedge clk);
					while (sb.pending() != 0)
						@(posedge clk);
				end
				default: begin
					src_idle_pct = 9;
					dst_stall_pct = 9;
				end
			endcase
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES)
				send_random_chunk();
		end

		// Close the file, then bytes that must be dropped
		send_chunk(TYPE_IEND, 0, 32'hAE42_6082, -1);
		for (int i = 0; i < TAIL_BYTES; i++)
			send_byte(8'($urandom_range(0, 255)));

		file_valid <= 1'b0;
		dst_stall_pct = 0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("file of %0d bytes in %0d cycles, %0d chunks checked", bytes_sent, cycles,
			sb.chunks_checked);
		$display("by class: other %0d, IHDR %0d, IDAT %0d, PLTE %0d, IEND %0d",
			sb.per_class[CLS_OTHER], sb.per_class[CLS_IHDR], sb.per_class[CLS_IDAT],
			sb.per_class[CLS_PLTE], sb.per_class[CLS_IEND]);
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
